### rtl/bsmh_pkg.sv
package bsmh_pkg;

   localparam int BYTE_W      = 8;
   localparam int KEY_LEN_W   = 16;
   localparam int WORD_W      = 32;
   localparam int REQ_DATA_W  = BYTE_W + KEY_LEN_W;
   localparam int RSP_DATA_W  = WORD_W;
   localparam int CSR_DATA_W  = WORD_W;
   localparam int BLOCK_N     = 12;

   localparam logic [3:0]        BLOCK_BYTES = 4'd12;
   localparam logic [WORD_W-1:0] GOLDEN      = 32'hdeadbeef;

   // block mixer: one add stage, then six mix rounds
   localparam int MIX_STAGES = 7;
   // final path: delay to line up with the block mixer, combine, seven rounds
   localparam int FIN_STAGES = MIX_STAGES + 9;

   typedef logic [BLOCK_N-1:0][BYTE_W-1:0] block_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
   } words_type;

   typedef struct packed {
      logic      vld;
      logic      own;
      words_type w;
   } mstage_type;

   typedef struct packed {
      logic      vld;
      logic      own;
      logic      raw;
      logic      pend;
      words_type w;
      block_type blk;
   } fstage_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

   // add the bytes of a block little-endian into the three words
   function automatic words_type add_block(input words_type w, input block_type blk);
      words_type r;
      r.a = w.a + blk[3:0];
      r.b = w.b + blk[7:4];
      r.c = w.c + blk[11:8];
      return r;
   endfunction

   function automatic words_type mix_step(input logic [2:0] k, input words_type x);
      words_type r;
      r = x;
      case (k)
         3'd0: begin
            r.a = (x.a - x.c) ^ rotl(x.c, 4);
            r.c = x.c + x.b;
         end
         3'd1: begin
            r.b = (x.b - x.a) ^ rotl(x.a, 6);
            r.a = x.a + x.c;
         end
         3'd2: begin
            r.c = (x.c - x.b) ^ rotl(x.b, 8);
            r.b = x.b + x.a;
         end
         3'd3: begin
            r.a = (x.a - x.c) ^ rotl(x.c, 16);
            r.c = x.c + x.b;
         end
         3'd4: begin
            r.b = (x.b - x.a) ^ rotl(x.a, 19);
            r.a = x.a + x.c;
         end
         3'd5: begin
            r.c = (x.c - x.b) ^ rotl(x.b, 4);
            r.b = x.b + x.a;
         end
         default: r = x;
      endcase
      return r;
   endfunction

   function automatic words_type final_step(input logic [2:0] k, input words_type x);
      words_type r;
      r = x;
      case (k)
         3'd0: r.c = (x.c ^ x.b) - rotl(x.b, 14);
         3'd1: r.a = (x.a ^ x.c) - rotl(x.c, 11);
         3'd2: r.b = (x.b ^ x.a) - rotl(x.a, 25);
         3'd3: r.c = (x.c ^ x.b) - rotl(x.b, 16);
         3'd4: r.a = (x.a ^ x.c) - rotl(x.c, 4);
         3'd5: r.b = (x.b ^ x.a) - rotl(x.a, 14);
         3'd6: r.c = (x.c ^ x.b) - rotl(x.b, 24);
         default: r = x;
      endcase
      return r;
   endfunction

endpackage

### rtl/byte_string_mix_hash_top.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata: data_byte, key_length; tuser: first_byte;
//                                       tlast: last_byte
// rsp       out  rsp_tvalid/rsp_tready  tdata: hash_value
// csr       in   csr_wr_en              csr_wr_data: seed
//
// One key byte is taken per cycle while req_tready is high. A hash leaves through the final-mix
// pipeline, after its last byte (or after the first item of an empty key), into a 32-entry
// result queue. req_tready drops while the queue has no free credit, and while a byte that
// continues a key without a first item needs words still in the final-mix pipeline. Reset
// is synchronous and clears seed, chaining words, block position, pipelines and queue.
module byte_string_mix_hash_top #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bsmh_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bsmh_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] data_byte, [23:8] key_length
   input  logic                             req_tuser,   // first_byte
   input  logic                             req_tlast,   // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bsmh_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [31:0] hash_value
);
   import bsmh_pkg::*;

   localparam int LEN_W     = (LENGTH_BITS < KEY_LEN_W) ? LENGTH_BITS : KEY_LEN_W;
   localparam int RSP_DEPTH = 32;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int CNT_W     = PTR_W + 1;

   // configuration and chaining state
   logic [WORD_W-1:0] seed_ff, seed_in;
   words_type         h_ff, h_in;        // words before the bytes of the open block
   words_type         mres_ff, mres_in;  // latest block-mix result
   logic [3:0]        pos_ff, pos_in;
   block_type         blk_ff, blk_in;

   mstage_type        mst_ff [MIX_STAGES];
   mstage_type        mst_in [MIX_STAGES];
   fstage_type        fst_ff [FIN_STAGES];
   fstage_type        fst_in [FIN_STAGES];

   logic [RSP_DATA_W-1:0] rsp_mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]      cred_ff, cred_in;

   // input fields
   logic [BYTE_W-1:0] data_byte;
   logic [WORD_W-1:0] len_w;
   logic              first, last;

   logic [WORD_W-1:0] init_w;
   words_type         init3;
   logic              acc, empty_key, full_blk, restart, needs_h;
   logic              mix_busy, fin_busy, res_push, rsp_pop, clr_own;
   logic [3:0]        eff_pos;
   block_type         new_blk;
   mstage_type        mout;
   fstage_type        fout;

   assign data_byte = req_tdata[BYTE_W-1:0];
   assign len_w     = WORD_W'(req_tdata[BYTE_W +: LEN_W]);
   assign first     = req_tuser;
   assign last      = req_tlast;

   assign init_w    = GOLDEN + len_w + seed_ff;
   assign init3     = '{a: init_w, b: init_w, c: init_w};
   assign empty_key = first && (len_w == '0);
   assign full_blk  = (pos_ff == BLOCK_BYTES);
   assign restart   = first || full_blk;
   assign eff_pos   = restart ? 4'd0 : pos_ff;

   // a full block is mixed only once another byte of the same key shows up
   assign needs_h   = !first && (full_blk || last);

   assign mout      = mst_ff[MIX_STAGES-1];
   assign fout      = fst_ff[FIN_STAGES-1];

   // in-flight work that will still rewrite the chaining words
   always_comb begin
      mix_busy = 1'b0;
      for (int j = 0; j < MIX_STAGES; j++) begin
         mix_busy = mix_busy | (mst_ff[j].vld & mst_ff[j].own);
      end
      fin_busy = 1'b0;
      for (int j = 0; j < FIN_STAGES; j++) begin
         fin_busy = fin_busy | (fst_ff[j].vld & fst_ff[j].own);
      end
   end

   assign req_tready = (cred_ff < CNT_W'(RSP_DEPTH)) && !(needs_h && fin_busy);
   assign acc        = req_tvalid && req_tready;
   assign clr_own    = acc && first;
   assign res_push   = acc && (empty_key || last);
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      new_blk          = restart ? '0 : blk_ff;
      new_blk[eff_pos] = data_byte;
   end

   // block position and open block
   always_comb begin
      seed_in = csr_wr_en ? csr_wr_data : seed_ff;
      pos_in  = pos_ff;
      blk_in  = blk_ff;
      if (acc) begin
         if (empty_key || last) begin
            pos_in = 4'd0;
            blk_in = '0;
         end else begin
            pos_in = eff_pos + 4'd1;
            blk_in = new_blk;
         end
      end
   end

   // block mixer: launch on the byte that follows a full block
   always_comb begin
      mst_in[0]     = '0;
      mst_in[0].vld = acc && !first && full_blk;
      mst_in[0].own = 1'b1;
      mst_in[0].w   = add_block(h_ff, blk_ff);
      for (int j = 1; j < MIX_STAGES; j++) begin
         mst_in[j].vld = mst_ff[j-1].vld;
         mst_in[j].own = mst_ff[j-1].own & !clr_own;
         mst_in[j].w   = mix_step(3'(j - 1), mst_ff[j-1].w);
      end
   end

   // final path: hold for the block mixer, combine words and block, then final rounds (not for an empty key)
   always_comb begin
      fstage_type fx;
      fst_in[0] = '0;
      if (acc && empty_key) begin
         fst_in[0].vld = 1'b1;
         fst_in[0].raw = 1'b1;
         fst_in[0].w   = init3;
      end else if (acc && last) begin
         fst_in[0].vld  = 1'b1;
         fst_in[0].own  = 1'b1;
         fst_in[0].pend = !first && (mix_busy || full_blk);
         fst_in[0].w    = first ? init3 : h_ff;
         fst_in[0].blk  = new_blk;
      end
      for (int j = 1; j < FIN_STAGES; j++) begin
         fx     = fst_ff[j-1];
         fx.own = fx.own & !clr_own;
         if (j == MIX_STAGES + 1) begin
            // base from the block mixer when its result was still in flight at launch
            fx.w = add_block(fx.pend ? mres_ff : fx.w, fx.blk);
         end else if ((j > MIX_STAGES + 1) && !fx.raw) begin
            fx.w = final_step(3'(j - MIX_STAGES - 2), fx.w);
         end
         fst_in[j] = fx;
      end
   end

   // chaining words: a new key reseeds, else take finished final and block mixes of this key
   always_comb begin
      h_in    = h_ff;
      mres_in = mout.vld ? mout.w : mres_ff;
      if (clr_own) begin
         h_in = init3;
      end else if (fout.vld && fout.own) begin
         h_in = fout.w;
      end else if (mout.vld && mout.own) begin
         h_in = mout.w;
      end
   end

   // result queue, credits counted from launch to pop
   always_comb begin
      wr_ptr_in = fout.vld ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rsp_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fcnt_in   = fcnt_ff + CNT_W'(fout.vld) - CNT_W'(rsp_pop);
      cred_in   = cred_ff + CNT_W'(res_push) - CNT_W'(rsp_pop);
   end

   assign rsp_tvalid = (fcnt_ff != '0);
   assign rsp_tdata  = rsp_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         h_ff      <= '0;
         pos_ff    <= 4'd0;
         blk_ff    <= '0;
         mst_ff    <= '{default: '0};
         fst_ff    <= '{default: '0};
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fcnt_ff   <= '0;
         cred_ff   <= '0;
      end else begin
         seed_ff   <= seed_in;
         h_ff      <= h_in;
         pos_ff    <= pos_in;
         blk_ff    <= blk_in;
         mst_ff    <= mst_in;
         fst_ff    <= fst_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fcnt_ff   <= fcnt_in;
         cred_ff   <= cred_in;
      end
   end

   // payload only
   always_ff @(posedge clock) begin
      mres_ff <= mres_in;
      if (fout.vld) begin
         rsp_mem_ff[wr_ptr_ff] <= fout.w.c;
      end
   end

endmodule
